/* hdl/cgi_pkg.sv */
// package: payload types, command and status structs for the contour grid interpolator
`timescale 1ns / 1ps
`default_nettype none
package cgi_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned CountBits = 9;
  localparam int unsigned MaxPoints = 256;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef struct packed {
    logic                        req_type;
    logic [7:0]                  point_index;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic signed [CoordBits-1:0] coord_z;
    logic [7:0]                  grid_row;
    logic [7:0]                  grid_column;
  } req_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic signed [CoordBits-1:0] out_z;
    logic                        status;
  } rsp_word_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;   // latch request, compute geometry
    logic       do_write;  // write store
    logic [1:0] rd_sel;    // 0: P0, 1: Pn, 2: side
    logic       rd_en;
    logic       acc_clr;
    logic       acc_add;   // add weighted term of last read
    logic       div_start;
    logic [1:0] axis;      // coordinate being divided
    logic       load_edge; // output = read point
    logic       res_store; // store divider result for axis
    logic       out_clear;
    logic       out_load;  // move finished result to output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_write;
    logic bad;        // status 1
    logic edge_row;   // row 0 or n
    logic div_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

/* hdl/cgi_ctrl.sv */
// controller state machine: sequences reads, accumulations and divisions
`timescale 1ns / 1ps
`default_nettype none
module cgi_ctrl
  import cgi_pkg::*;
(
  input  wire  logic    clk_i,
  input  wire  logic    rst_ni,
  input  wire  logic    in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire  logic    out_stall_i,
  input  wire  dp_sts_t sts_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDec   = 4'd1;
  localparam logic [3:0] StRd    = 4'd2;
  localparam logic [3:0] StAcc   = 4'd3;
  localparam logic [3:0] StDivGo = 4'd4;
  localparam logic [3:0] StDivW  = 4'd5;
  localparam logic [3:0] StDone  = 4'd6;
  localparam logic [3:0] StEdge  = 4'd7;

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [1:0] pt_q, pt_d;
  logic       ov_q, ov_d;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    pt_d    = pt_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    cmd_o.axis   = axis_q;
    cmd_o.rd_sel = pt_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    in_stall_o = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.capture = 1'b1;
          state_d = StDec;
        end
      end
      StDec: begin
        axis_d = 2'd0;
        pt_d   = 2'd0;
        if (sts_i.is_write) begin
          cmd_o.do_write  = 1'b1;
          cmd_o.out_clear = 1'b1;
          state_d = StDone;
        end else if (sts_i.bad) begin
          cmd_o.out_clear = 1'b1;
          state_d = StDone;
        end else begin
          cmd_o.rd_en = 1'b1;
          // edge rows read their own slot through the side pointer
          cmd_o.rd_sel = sts_i.edge_row ? 2'd2 : 2'd0;
          cmd_o.acc_clr = 1'b1;
          state_d = sts_i.edge_row ? StEdge : StAcc;
        end
      end
      StEdge: begin
        cmd_o.load_edge = 1'b1;
        state_d = StDone;
      end
      StRd: begin
        cmd_o.rd_en = 1'b1;
        state_d = StAcc;
      end
      StAcc: begin
        cmd_o.acc_add = 1'b1;
        if (pt_q == 2'd2) begin
          state_d = StDivGo;
        end else begin
          pt_d = pt_q + 2'd1;
          state_d = StRd;
        end
      end
      StDivGo: begin
        cmd_o.div_start = 1'b1;
        state_d = StDivW;
      end
      StDivW: begin
        if (!sts_i.div_busy) begin
          cmd_o.res_store = 1'b1;
          if (axis_q == 2'd2) begin
            state_d = StDone;
          end else begin
            axis_d = axis_q + 2'd1;
            pt_d = 2'd0;
            cmd_o.acc_clr = 1'b1;
            state_d = StRd;
          end
        end
      end
      StDone: begin
        if (!ov_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // rd in StRd uses pt_q which points to next point
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q  <= 2'd0;
      pt_q    <= 2'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      pt_q    <= pt_d;
      ov_q    <= ov_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/cgi_div.sv */
// iterative signed divider, one quotient bit a cycle, truncating
`timescale 1ns / 1ps
`default_nettype none
module cgi_div #(
  parameter int unsigned NumBits = 64,
  parameter int unsigned DenBits = 24
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic signed [NumBits-1:0] num_i,
  input  wire logic [DenBits-1:0]        den_i,
  output logic                           busy_o,
  output logic signed [NumBits-1:0]      quo_o
);

  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] q_q;
  logic [DenBits:0]   r_q;
  logic [DenBits-1:0] d_q;
  logic               neg_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q;
  logic [DenBits:0]   r_sh;
  logic [NumBits-1:0] mag;

  assign mag  = num_i[NumBits-1] ? (~num_i + 1'b1) : num_i;
  assign r_sh = {r_q[DenBits-1:0], q_q[NumBits-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntBits'(NumBits);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= mag;
      r_q   <= '0;
      d_q   <= den_i;
      neg_q <= num_i[NumBits-1];
    end else if (busy_q) begin
      if (r_sh >= {1'b0, d_q}) begin
        r_q <= r_sh - {1'b0, d_q};
        q_q <= {q_q[NumBits-2:0], 1'b1};
      end else begin
        r_q <= r_sh;
        q_q <= {q_q[NumBits-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q | start_i;
  assign quo_o  = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule
`default_nettype wire

/* hdl/cgi_dp.sv */
// datapath: contour store, grid decode, weighted sum and divider
`timescale 1ns / 1ps
`default_nettype none
module cgi_dp
  import cgi_pkg::*;
(
  input  wire  logic                 clk_i,
  input  wire  logic                 rst_ni,
  input  wire  req_word_t            req_i,
  input  wire  logic [CountBits-1:0] count_i,
  input  wire  dp_cmd_t              cmd_i,
  output dp_sts_t                    sts_o,
  output rsp_word_t                  rsp_o
);

  localparam int unsigned AddrBits = $clog2(MaxPoints);
  localparam int unsigned AccBits  = 64;

  logic [3*CoordBits-1:0] mem_q [MaxPoints];
  logic [3*CoordBits-1:0] rd_q;
  req_word_t  req_q;
  logic [7:0] n_q, m_q, j_q, side_q;
  logic       bad_q, edge_q;
  logic [15:0] w_q [3];
  logic [15:0] den_q;
  logic signed [AccBits-1:0] acc_q;
  rsp_word_t  rsp_q;
  rsp_word_t  out_q;
  logic [1:0] last_sel_q;

  // grid decode
  logic [CountBits-1:0] cnt;
  logic [7:0] n, i, c, m, j, side;
  logic       bad, edge_r;
  always_comb begin
    cnt = (count_i > CountBits'(MaxPoints)) ? CountBits'(MaxPoints) : count_i;
    n = cnt[8:1];
    i = req_i.grid_row;
    c = req_i.grid_column;
    m = (i <= {1'b0, n[7:1]}) ? i : n - i;
    edge_r = (i == 8'd0) || (i == n);
    bad = 1'b0;
    if (req_i.req_type == ReqWrite) begin
      bad = ({1'b0, req_i.point_index} >= 9'(MaxPoints));
    end else if (n == 8'd0 || i > n) begin
      bad = 1'b1;
    end else if (edge_r) begin
      bad = (c != 8'd0);
    end else begin
      bad = ({1'b0, c} > {m, 1'b0});
    end
    j    = (c <= m) ? c : 8'({m, 1'b0} - {1'b0, c});
    side = (c <= m) ? i : 8'({n, 1'b0} - {1'b0, i});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_i;
      n_q    <= n;
      m_q    <= m;
      j_q    <= j;
      side_q <= side;
      bad_q  <= bad;
      edge_q <= edge_r;
      w_q[0] <= 16'(j) * 16'(n - i);
      w_q[1] <= 16'(j) * 16'(i);
      w_q[2] <= 16'(m - j) * 16'(n);
      den_q  <= 16'(m) * 16'(n);
    end
  end

  // contour store
  logic [7:0] rd_pt;
  always_comb begin
    case (cmd_i.rd_sel)
      2'd0:    rd_pt = 8'd0;
      2'd1:    rd_pt = n_q;
      default: rd_pt = side_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write && !bad_q) begin
      mem_q[req_q.point_index[AddrBits-1:0]] <=
        {req_q.coord_x, req_q.coord_y, req_q.coord_z};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_pt[AddrBits-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) last_sel_q <= cmd_i.rd_sel;
  end

  // coordinate of read point for current axis
  logic signed [CoordBits-1:0] coord;
  always_comb begin
    case (cmd_i.axis)
      2'd0:    coord = rd_q[3*CoordBits-1:2*CoordBits];
      2'd1:    coord = rd_q[2*CoordBits-1:CoordBits];
      default: coord = rd_q[CoordBits-1:0];
    endcase
  end

  logic signed [CoordBits+16:0] prod;
  assign prod = coord * $signed({1'b0, w_q[last_sel_q]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr)      acc_q <= '0;
    else if (cmd_i.acc_add) acc_q <= acc_q + AccBits'(prod);
  end

  logic signed [AccBits-1:0] quo;
  logic div_busy;
  cgi_div #(.NumBits(AccBits), .DenBits(16)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (acc_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_clear) begin
      rsp_q <= rsp_word_t'({{(3*CoordBits){1'b0}}, bad_q});
    end else if (cmd_i.load_edge) begin
      rsp_q.out_x  <= rd_q[3*CoordBits-1:2*CoordBits];
      rsp_q.out_y  <= rd_q[2*CoordBits-1:CoordBits];
      rsp_q.out_z  <= rd_q[CoordBits-1:0];
      rsp_q.status <= 1'b0;
    end else if (cmd_i.res_store) begin
      rsp_q.status <= 1'b0;
      case (cmd_i.axis)
        2'd0:    rsp_q.out_x <= quo[CoordBits-1:0];
        2'd1:    rsp_q.out_y <= quo[CoordBits-1:0];
        default: rsp_q.out_z <= quo[CoordBits-1:0];
      endcase
    end
  end

  // output register, holds the result while the next word is worked on
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= rsp_q;
  end

  // edge rows read slot 0 or n directly
  assign sts_o.is_write = (req_q.req_type == ReqWrite);
  assign sts_o.bad      = bad_q;
  assign sts_o.edge_row = edge_q;
  assign sts_o.div_busy = div_busy;
  assign rsp_o = out_q;

  logic unused;
  assign unused = ^{m_q, j_q};

endmodule
`default_nettype wire

/* hdl/contour_grid_interpolator_unit.sv */
// top level: contour grid interpolator with apb count register
// Stores up to MaxPoints contour points (x, y, z in signed Q16.16) and answers
// grid queries. A write word passes through decode, finish and the return to
// idle before the next word can be accepted. A query on an inner row works on
// x, y and z in turn: three store reads with their multiply-accumulates and
// the divider launch, then the shared 64-bit restoring divider, which works
// out the quotient bit by bit, and the storing of its result; finish and the
// return to idle follow. Edge-row queries read the point and load it directly;
// rejected queries go from decode to finish. One word is worked on at a time;
// the finished result moves to an output register, so the next word is accepted
// while it waits, and a second finished result holds off the input until the
// first is taken. contour_count is written at byte address 0.
`timescale 1ns / 1ps
`default_nettype none
module contour_grid_interpolator_unit
  import cgi_pkg::*;
(
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        in_valid_i,
  output logic              in_stall_o,
  input  wire  req_word_t   in_data_i,
  output logic              out_valid_o,
  input  wire  logic        out_stall_i,
  output rsp_word_t         out_data_o,
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic [0:0]  paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [CountBits-1:0] count_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // register 0 at address 0; other addresses ignored
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else if (psel && penable && pwrite && paddr == 1'b0) count_q <= pwdata[CountBits-1:0];
  end
  assign prdata = (paddr == 1'b0) ? 32'(count_q) : 32'd0;

  cgi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cgi_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (in_data_i),
    .count_i (count_q),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .rsp_o   (out_data_o)
  );

endmodule
`default_nettype wire
